@@ sv/psc_pkg.sv @@
// Shared types and constants for the packed string compare pipeline.
package psc_pkg;

  localparam int unsigned NumElem = 16;

  typedef enum logic [1:0] {
    AGG_EQUAL_ANY     = 2'd0,
    AGG_RANGES        = 2'd1,
    AGG_EQUAL_EACH    = 2'd2,
    AGG_EQUAL_ORDERED = 2'd3
  } agg_e;

  typedef enum logic [1:0] {
    POL_PLAIN       = 2'd0,
    POL_INVERT      = 2'd1,
    POL_PLAIN_ALT   = 2'd2,
    POL_INVERT_TEXT = 2'd3
  } pol_e;

  typedef logic [NumElem-1:0][NumElem-1:0] pair_mat_t;

  // Control fields carried alongside the data through the pipeline.
  typedef struct packed {
    logic words;
    agg_e agg;
    pol_e pol;
    logic high_sel;
  } ctl_t;

endpackage

@@ sv/packed_string_compare_top.sv @@
// Packed string compare, four-stage pipeline with a global stall.
// Each beat passes through the stage 1, stage 2, stage 3 and output registers in order.
// Throughput: one beat per cycle; all stages advance when the output register
// is empty or being drained, and an output stall holds every stage in place.
// Reset clears the stage valid bits only; payload registers are not reset.
module packed_string_compare_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_lo[63:0], first_hi[127:64], second_lo[191:128], second_hi[255:192],
  // control_byte[263:256], len_given[264], first_length_raw[328:265],
  // second_length_raw[392:329], zero pad[399:393]
  input  logic [399:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_mask[15:0], match_index[20:16], zero_flag[21], sign_flag[22],
  // carry_flag[23], overflow_flag[24], mask_lo[88:25], mask_hi[152:89],
  // zero pad[159:153]
  output logic [159:0] m_axis_tdata
);

  localparam int unsigned N = psc_pkg::NumElem;

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;
  assign adv = !v4_q || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------- stage 1: split, lengths, compares
  logic [127:0] a_w, b_w;
  logic [7:0]   ctl_w;
  logic         sgn_w, words_w;
  logic [63:0]  l1raw_w, l2raw_w;
  logic signed [16:0] ea [N], eb [N];
  logic [4:0]   n_w, len1_d, len2_d, zt1, zt2;
  logic [63:0]  abs1, abs2;
  psc_pkg::pair_mat_t eq_d, ge_d, le_d;
  psc_pkg::pair_mat_t eq_q, ge_q, le_q;
  logic [4:0]   len1_q, len2_q;
  psc_pkg::ctl_t c1_d, c1_q, c2_q, c3_q;

  assign a_w     = s_axis_tdata[127:0];
  assign b_w     = s_axis_tdata[255:128];
  assign ctl_w   = s_axis_tdata[263:256];
  assign l1raw_w = s_axis_tdata[328:265];
  assign l2raw_w = s_axis_tdata[392:329];
  assign words_w = ctl_w[0];
  assign sgn_w   = ctl_w[1];
  assign n_w     = words_w ? 5'd8 : 5'd16;
  assign abs1    = l1raw_w[63] ? (64'd0 - l1raw_w) : l1raw_w;
  assign abs2    = l2raw_w[63] ? (64'd0 - l2raw_w) : l2raw_w;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (words_w) begin
        if (i < 8) begin
          ea[i] = {sgn_w & a_w[16*i+15], a_w[16*i +: 16]};
          eb[i] = {sgn_w & b_w[16*i+15], b_w[16*i +: 16]};
        end else begin
          ea[i] = '0;
          eb[i] = '0;
        end
      end else begin
        ea[i] = {{9{sgn_w & a_w[8*i+7]}}, a_w[8*i +: 8]};
        eb[i] = {{9{sgn_w & b_w[8*i+7]}}, b_w[8*i +: 8]};
      end
    end
    zt1 = n_w;
    zt2 = n_w;
    for (int i = N - 1; i >= 0; i--) begin
      if (5'(i) < n_w && ea[i] == '0) zt1 = 5'(i);
      if (5'(i) < n_w && eb[i] == '0) zt2 = 5'(i);
    end
    if (s_axis_tdata[264]) begin
      len1_d = (abs1 >= 64'(n_w)) ? n_w : abs1[4:0];
      len2_d = (abs2 >= 64'(n_w)) ? n_w : abs2[4:0];
    end else begin
      len1_d = zt1;
      len2_d = zt2;
    end
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        eq_d[i][j] = eb[j] == ea[i];
        ge_d[i][j] = $signed(eb[j]) >= $signed(ea[i]);
        le_d[i][j] = $signed(eb[j]) <= $signed(ea[i]);
      end
    end
    c1_d.words    = words_w;
    c1_d.agg      = psc_pkg::agg_e'(ctl_w[3:2]);
    c1_d.pol      = psc_pkg::pol_e'(ctl_w[5:4]);
    c1_d.high_sel = ctl_w[6];
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      eq_q <= eq_d; ge_q <= ge_d; le_q <= le_d;
      len1_q <= len1_d; len2_q <= len2_d; c1_q <= c1_d;
    end
  end

  // ---------------- stage 2: pair bits with validity override
  psc_pkg::pair_mat_t pb_d, pb_q;
  logic [4:0] len2_2_q;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        logic v1, v2;
        v1 = 5'(i) < len1_q;
        v2 = 5'(j) < len2_q;
        if (!v1 && !v2)      pb_d[i][j] = c1_q.agg[1];
        else if (!v1)        pb_d[i][j] = c1_q.agg == psc_pkg::AGG_EQUAL_ORDERED;
        else if (!v2)        pb_d[i][j] = 1'b0;
        else if (c1_q.agg == psc_pkg::AGG_RANGES)
          pb_d[i][j] = (i % 2 == 0) ? ge_q[i][j] : le_q[i][j];
        else                 pb_d[i][j] = eq_q[i][j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v1_q) begin
      pb_q <= pb_d; len2_2_q <= len2_q; c2_q <= c1_q;
    end
  end

  // ---------------- stage 3: aggregation and polarity
  logic [N-1:0] res2_d, res2_q;

  always_comb begin
    logic [N-1:0] r1, all;
    logic [4:0]   n;
    n   = c2_q.words ? 5'd8 : 5'd16;
    all = c2_q.words ? 16'h00FF : 16'hFFFF;
    for (int j = 0; j < N; j++) begin
      logic bit_v;
      bit_v = 1'b0;
      unique case (c2_q.agg)
        psc_pkg::AGG_EQUAL_ANY: begin
          for (int i = 0; i < N; i++) if (5'(i) < n) bit_v |= pb_q[i][j];
        end
        psc_pkg::AGG_RANGES: begin
          for (int i = 0; i < N; i += 2)
            if (5'(i + 1) < n) bit_v |= pb_q[i][j] & pb_q[i+1][j];
        end
        psc_pkg::AGG_EQUAL_EACH: bit_v = pb_q[j][j];
        psc_pkg::AGG_EQUAL_ORDERED: begin
          bit_v = 1'b1;
          for (int i = 0; i < N; i++)
            if (i + j < N && 5'(i + j) < n) bit_v &= pb_q[i][4'(i + j)];
        end
        default: bit_v = 1'b0;
      endcase
      r1[j] = bit_v;
    end
    unique case (c2_q.pol)
      psc_pkg::POL_INVERT:      res2_d = ~r1 & all;
      psc_pkg::POL_INVERT_TEXT:
        res2_d = (r1 ^ N'((17'd1 << len2_2_q) - 17'd1)) & all;
      default:                  res2_d = r1 & all;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv && v2_q) begin
      res2_q <= res2_d; c3_q <= c2_q;
    end
  end

  // Flags need the lengths; carry them alongside stage 3.
  logic zf2_q, sf2_q, zf3_q, sf3_q;
  always_ff @(posedge clk_i) begin
    if (adv && v1_q) begin
      zf2_q <= len2_q != (c1_q.words ? 5'd8 : 5'd16);
      sf2_q <= len1_q != (c1_q.words ? 5'd8 : 5'd16);
    end
    if (adv && v2_q) begin
      zf3_q <= zf2_q; sf3_q <= sf2_q;
    end
  end

  // ---------------- stage 4: index, mask value, output register
  logic [159:0] out_d, out_q;

  always_comb begin
    logic [4:0]   idx;
    logic [127:0] mv;
    idx = c3_q.words ? 5'd8 : 5'd16;
    if (c3_q.high_sel) begin
      for (int i = 0; i < N; i++) if (res2_q[i]) idx = 5'(i);
    end else begin
      for (int i = N - 1; i >= 0; i--) if (res2_q[i]) idx = 5'(i);
    end
    mv = '0;
    if (!c3_q.high_sel) mv = {112'd0, res2_q};
    else if (c3_q.words) begin
      for (int i = 0; i < 8; i++) mv[16*i +: 16] = {16{res2_q[i]}};
    end else begin
      for (int i = 0; i < N; i++) mv[8*i +: 8] = {8{res2_q[i]}};
    end
    out_d = {7'd0, mv, res2_q[0], |res2_q, sf3_q, zf3_q, idx, res2_q};
  end

  always_ff @(posedge clk_i) begin
    if (adv && v3_q) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed under stall");
  a_cf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23] == (m_axis_tdata[15:0] != 16'd0))
    else $error("carry flag disagrees with result mask");
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[20:16] <= 5'd16)
    else $error("match index out of range");
`endif

endmodule
